// ===== sv/serial_loaded_bank_mapper_top_defines.svh =====
// ----------------------------------------------------------------------------
// Serial loaded bank mapper assertion macros
// Shared assertion forms, clocked on clk with arst_n as the disable.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LOADED_BANK_MAPPER_TOP_DEFINES_SVH
`define SERIAL_LOADED_BANK_MAPPER_TOP_DEFINES_SVH

// Condition that must hold at every edge outside reset
`define SLBM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define SLBM_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== sv/slbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial loaded bank mapper package
// Widths, codes and shared structs of the bank mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slbm_pkg;

	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int MAP_W    = 22;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int SREG_W   = 5;
	localparam int SCNT_W   = 3;

	// Bus access kinds
	typedef enum logic [1:0] {
		ACT_CPU_READ  = 2'd0,
		ACT_CPU_WRITE = 2'd1,
		ACT_PPU_READ  = 2'd2,
		ACT_PPU_WRITE = 2'd3
	} action_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRG_COUNT = 1'd0,
		CFG_CHR_COUNT = 1'd1
	} cfg_index_t;

	// Serial load targets (address bits 14:13)
	typedef enum logic [1:0] {
		TGT_CONTROL = 2'd0,
		TGT_CHR0    = 2'd1,
		TGT_CHR1    = 2'd2,
		TGT_PRG     = 2'd3
	} target_t;

	// PRG banking modes (control bits 3:2)
	typedef enum logic [1:0] {
		PRG_32K_A     = 2'd0,
		PRG_32K_B     = 2'd1,
		PRG_FIX_FIRST = 2'd2,
		PRG_FIX_LAST  = 2'd3
	} prg_mode_t;

	localparam logic [SREG_W-1:0] CONTROL_RESET = 5'h1C;
	localparam logic [CFG_W-1:0]  PRG_COUNT_RESET = 8'd2;
	localparam logic [CFG_W-1:0]  CHR_COUNT_RESET = 8'd0;
	localparam logic [SCNT_W-1:0] SHIFT_LAST = 3'd5;

	// Banking state seen by the translator
	typedef struct packed {
		logic [SREG_W-1:0] control;
		logic [4:0]        chr_low;
		logic [4:0]        chr_high;
		logic [3:0]        chr_full;   // bits 4:1 of the 8 KiB bank
		logic [2:0]        prg_wide;
		logic [3:0]        prg_high;
		logic [3:0]        prg_low;
		logic [CFG_W-1:0]  prg_count;
		logic [CFG_W-1:0]  chr_count;
	} bank_state_t;

	// One result word
	typedef struct packed {
		logic             hit;
		logic             prg_ram_hit;
		logic [MAP_W-1:0] xlat_addr;
	} result_t;

endpackage

// ===== sv/slbm_req_if.sv =====
// ----------------------------------------------------------------------------
// Bus access channel
// Valid/ready channel carrying one bus access per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slbm_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 action;
	logic [slbm_pkg::ADDR_W-1:0] bus_addr;
	logic [slbm_pkg::DATA_W-1:0] write_data;

	modport source (output valid, action, bus_addr, write_data, input ready);
	modport sink   (input valid, action, bus_addr, write_data, output ready);
endinterface

// ===== sv/slbm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Mapping result channel
// Valid/ready channel carrying one translation result per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slbm_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic                       prg_ram_hit;
	logic [slbm_pkg::MAP_W-1:0] xlat_addr;

	modport source (output valid, hit, prg_ram_hit, xlat_addr, input ready);
	modport sink   (input valid, hit, prg_ram_hit, xlat_addr, output ready);
endinterface

// ===== sv/slbm_regs.sv =====
// ----------------------------------------------------------------------------
// Bank mapper register file
// Serial load shifter, control and bank registers, configuration counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_loaded_bank_mapper_top_defines.svh"

module slbm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [slbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [slbm_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          rom_wr,     // cpu write at 0x8000 and up
	input  logic [slbm_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [slbm_pkg::DATA_W-1:0]   wr_data,
	output slbm_pkg::bank_state_t         state
);

	logic [slbm_pkg::SREG_W-1:0] shift_q, shift_d;
	logic [slbm_pkg::SCNT_W-1:0] count_q, count_d;
	logic [slbm_pkg::SREG_W-1:0] control_q, control_d;
	logic [4:0]                  chr_low_q, chr_low_d;
	logic [4:0]                  chr_high_q, chr_high_d;
	logic [3:0]                  chr_full_q, chr_full_d;
	logic [2:0]                  prg_wide_q, prg_wide_d;
	logic [3:0]                  prg_high_q, prg_high_d;
	logic [3:0]                  prg_low_q, prg_low_d;
	logic [slbm_pkg::CFG_W-1:0]  prg_count_q, chr_count_q;

	logic [slbm_pkg::SREG_W-1:0] shift_new;
	logic [slbm_pkg::SCNT_W-1:0] count_new;
	logic                        load;

	// Serial load and register update
	always_comb begin
		shift_d    = shift_q;
		count_d    = count_q;
		control_d  = control_q;
		chr_low_d  = chr_low_q;
		chr_high_d = chr_high_q;
		chr_full_d = chr_full_q;
		prg_wide_d = prg_wide_q;
		prg_high_d = prg_high_q;
		prg_low_d  = prg_low_q;
		shift_new  = {wr_data[0], shift_q[slbm_pkg::SREG_W-1:1]};
		count_new  = count_q + 3'd1;
		load       = 1'b0;
		if (rom_wr) begin
			if (wr_data[7]) begin
				// reset word: clear shifter, force fixed-last PRG mode
				shift_d   = '0;
				count_d   = '0;
				control_d = control_q | 5'h0C;
			end else if (count_new >= slbm_pkg::SHIFT_LAST) begin
				load    = 1'b1;
				shift_d = '0;
				count_d = '0;
			end else begin
				shift_d = shift_new;
				count_d = count_new;
			end
		end
		// fifth bit: commit to the register chosen by address bits 14:13
		if (load) begin
			case (slbm_pkg::target_t'(wr_addr[14:13]))
				slbm_pkg::TGT_CONTROL: control_d = shift_new;
				slbm_pkg::TGT_CHR0: begin
					if (control_q[4]) chr_low_d = shift_new;
					else              chr_full_d = shift_new[4:1];
				end
				slbm_pkg::TGT_CHR1: begin
					if (control_q[4]) chr_high_d = shift_new;
				end
				slbm_pkg::TGT_PRG: begin
					case (slbm_pkg::prg_mode_t'(control_q[3:2]))
						slbm_pkg::PRG_32K_A,
						slbm_pkg::PRG_32K_B:     prg_wide_d = shift_new[3:1];
						slbm_pkg::PRG_FIX_FIRST: prg_high_d = shift_new[3:0];
						default:                 prg_low_d  = shift_new[3:0];
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= '0;
			count_q    <= '0;
			control_q  <= slbm_pkg::CONTROL_RESET;
			chr_low_q  <= '0;
			chr_high_q <= '0;
			chr_full_q <= '0;
			prg_wide_q <= '0;
			prg_high_q <= '0;
			prg_low_q  <= '0;
		end else begin
			shift_q    <= shift_d;
			count_q    <= count_d;
			control_q  <= control_d;
			chr_low_q  <= chr_low_d;
			chr_high_q <= chr_high_d;
			chr_full_q <= chr_full_d;
			prg_wide_q <= prg_wide_d;
			prg_high_q <= prg_high_d;
			prg_low_q  <= prg_low_d;
		end
	end

	// Cartridge configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= slbm_pkg::PRG_COUNT_RESET;
			chr_count_q <= slbm_pkg::CHR_COUNT_RESET;
		end else if (cfg_we) begin
			case (slbm_pkg::cfg_index_t'(cfg_index))
				slbm_pkg::CFG_PRG_COUNT: prg_count_q <= cfg_data;
				slbm_pkg::CFG_CHR_COUNT: chr_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign state = '{
		control:   control_q,
		chr_low:   chr_low_q,
		chr_high:  chr_high_q,
		chr_full:  chr_full_q,
		prg_wide:  prg_wide_q,
		prg_high:  prg_high_q,
		prg_low:   prg_low_q,
		prg_count: prg_count_q,
		chr_count: chr_count_q
	};

	`SLBM_ASSERT_ALWAYS(a_count_range, count_q < slbm_pkg::SHIFT_LAST, "shift count past four")
	`SLBM_ASSERT_NEXT(a_reset_word, rom_wr && wr_data[7], control_q[3:2] == 2'b11 && count_q == '0, "reset word did not force PRG mode 3")
	`SLBM_ASSERT_NEXT(a_fifth_clears, rom_wr && !wr_data[7] && count_q == 3'd4, count_q == '0 && shift_q == '0, "shifter not cleared after load")
	`SLBM_ASSERT_NEXT(a_chr1_8k, rom_wr && !wr_data[7] && count_q == 3'd4 && wr_addr[14:13] == slbm_pkg::TGT_CHR1 && !control_q[4], $stable(chr_high_q), "CHR bank 1 loaded in 8 KiB mode")

endmodule

// ===== sv/slbm_xlate.sv =====
// ----------------------------------------------------------------------------
// Bank mapper address translation
// Decodes one bus access and forms the ROM or RAM offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slbm_xlate (
	input  logic [1:0]                  action,
	input  logic [slbm_pkg::ADDR_W-1:0] bus_addr,
	input  slbm_pkg::bank_state_t       state,
	output slbm_pkg::result_t           result
);

	logic [slbm_pkg::MAP_W-1:0] prg_addr, chr_addr;
	logic [slbm_pkg::CFG_W-1:0] last_bank;
	logic [4:0]                 chr_bank;

	// PRG offset by banking mode
	always_comb begin
		last_bank = state.prg_count - 8'd1;
		case (slbm_pkg::prg_mode_t'(state.control[3:2]))
			slbm_pkg::PRG_32K_A,
			slbm_pkg::PRG_32K_B:
				prg_addr = {4'd0, state.prg_wide, bus_addr[14:0]};
			slbm_pkg::PRG_FIX_FIRST:
				prg_addr = bus_addr[14] ? {4'd0, state.prg_high, bus_addr[13:0]}
				                        : {8'd0, bus_addr[13:0]};
			default:
				prg_addr = bus_addr[14] ? {last_bank, bus_addr[13:0]}
				                        : {4'd0, state.prg_low, bus_addr[13:0]};
		endcase
	end

	// CHR offset, 4 KiB halves or one 8 KiB bank
	always_comb begin
		chr_bank = bus_addr[12] ? state.chr_high : state.chr_low;
		if (state.control[4]) chr_addr = {5'd0, chr_bank, bus_addr[11:0]};
		else                  chr_addr = {5'd0, state.chr_full, bus_addr[12:0]};
	end

	// Access decode
	always_comb begin
		result = '0;
		case (slbm_pkg::action_t'(action))
			slbm_pkg::ACT_CPU_READ,
			slbm_pkg::ACT_CPU_WRITE: begin
				if (bus_addr[15:13] == 3'b011) begin
					result.hit         = 1'b1;
					result.prg_ram_hit = 1'b1;
				end else if (bus_addr[15] && action == slbm_pkg::ACT_CPU_READ) begin
					result.hit       = 1'b1;
					result.xlat_addr = prg_addr;
				end
			end
			default: begin
				if (bus_addr[15:13] == 3'b000) begin
					if (state.chr_count == '0) begin
						result.hit       = 1'b1;
						result.xlat_addr = {6'd0, bus_addr};
					end else if (action == slbm_pkg::ACT_PPU_READ) begin
						result.hit       = 1'b1;
						result.xlat_addr = chr_addr;
					end
				end
			end
		endcase
	end

endmodule

// ===== sv/serial_loaded_bank_mapper_top.sv =====
// ----------------------------------------------------------------------------
// Serial loaded bank mapper
// Pipeline: a word accepted into the input register feeds the translator and
// register update, whose result lands in the output register.
// Throughput: one bus access per cycle while the output register is free.
// Reset: arst_n clears the pipeline, shifter and banks; control comes up in
// PRG mode 3, PRG bank count 2, CHR bank count 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_loaded_bank_mapper_top (
	input  logic                           clk,
	input  logic                           arst_n,
	slbm_req_if.sink                       req,
	slbm_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [slbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [slbm_pkg::CFG_W-1:0]     cfg_data
);

	logic                        valid_s1;
	logic [1:0]                  action_s1;
	logic [slbm_pkg::ADDR_W-1:0] addr_s1;
	logic [slbm_pkg::DATA_W-1:0] data_s1;
	logic                        valid_s2;
	slbm_pkg::result_t           result_s2;

	slbm_pkg::bank_state_t state;
	slbm_pkg::result_t     result;
	logic                  s2_free, advance, rom_wr;

	// Handshake: stage 1 moves on whenever the output register is free
	assign s2_free   = !valid_s2 || rsp.ready;
	assign advance   = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s2_free;
	assign rom_wr    = advance && action_s1 == slbm_pkg::ACT_CPU_WRITE && addr_s1[15];

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (req.ready) valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			addr_s1   <= req.bus_addr;
			data_s1   <= req.write_data;
		end
	end

	slbm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rom_wr    (rom_wr),
		.wr_addr   (addr_s1),
		.wr_data   (data_s1),
		.state     (state)
	);

	slbm_xlate u_xlate (
		.action   (action_s1),
		.bus_addr (addr_s1),
		.state    (state),
		.result   (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (s2_free) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance) result_s2 <= result;
	end

	assign rsp.valid       = valid_s2;
	assign rsp.hit         = result_s2.hit;
	assign rsp.prg_ram_hit = result_s2.prg_ram_hit;
	assign rsp.xlat_addr   = result_s2.xlat_addr;

endmodule
